@@ hdl/run_grouped_class_count_merger_defines.svh @@
// Assertion macros for the run-grouped class count merger.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef RUN_GROUPED_CLASS_COUNT_MERGER_DEFINES_SVH
`define RUN_GROUPED_CLASS_COUNT_MERGER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RGCM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define RGCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RGCM_ASSERT(lbl, expr, msg)
`define RGCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/rgcm_pkg.sv @@
// Shared types and constants of the run-grouped class count merger.
// No dependencies; imported by every module of the block.
package rgcm_pkg;

  localparam int KEY_W     = 64;
  localparam int CLASS_W   = 12;
  localparam int TOTAL_W   = 32;
  localparam int MAP_W     = CLASS_W + 1;
  localparam int NONE_IDX  = CLASS_W;
  localparam int OP_W      = 2;

  localparam int CLASS_TABLE_DEPTH_DEF = 4096;
  localparam int GROUP_CAPACITY_DEF    = 16;

  // Input tdata layout, lowest bit first.
  localparam int S_FIELDS_W = 2 * KEY_W + CLASS_W + TOTAL_W + CLASS_W + 1;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int S_UMI_LO   = KEY_W;
  localparam int S_CLS_LO   = 2 * KEY_W;
  localparam int S_AMT_LO   = S_CLS_LO + CLASS_W;
  localparam int S_MRG_LO   = S_AMT_LO + TOTAL_W;
  localparam int S_NONE_BIT = S_MRG_LO + CLASS_W;

  // Output tdata layout, lowest bit first.
  localparam int M_FIELDS_W = 2 * KEY_W + CLASS_W + TOTAL_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT,
    ST_ACCUM
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [CLASS_W-1:0] cls;
    logic [TOTAL_W-1:0] total;
  } entry_t;

  typedef struct packed {
    logic               accum;
    logic               shift;
    logic [CLASS_W-1:0] cls;
    logic [TOTAL_W-1:0] amount;
  } cell_cmd_t;

endpackage

@@ hdl/run_grouped_class_count_merger.sv @@
// Run-grouped class count merger. For a data record the class table is read
// when the record is accepted; the registered entry is summed into the chain
// of group cells in the next cycle, or, when the record opens a new
// barcode/UMI key, after the stored group has been emitted. On a key change
// or a flush the stored group is emitted one entry per cycle while the
// output is not stalled, by shifting the cell chain into the output
// register. Results come in order of first appearance; tlast marks the last
// entry of a group and tuser flags a group that lost classes because the
// store was full.
`include "run_grouped_class_count_merger_defines.svh"

module run_grouped_class_count_merger import rgcm_pkg::*; #(
  parameter int CLASS_TABLE_DEPTH = CLASS_TABLE_DEPTH_DEF,
  parameter int GROUP_CAPACITY    = GROUP_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // barcode, umi, class_index, amount, merged_class, maps_to_none, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // opcode
  input  logic [OP_W-1:0]      s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_barcode, out_umi, out_class, out_total, zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  // group_overflowed
  output logic                 m_tuser,
  // last_of_group
  output logic                 m_tlast
);

  localparam int ADDR_W = $clog2(CLASS_TABLE_DEPTH);
  localparam int FILL_W = $clog2(GROUP_CAPACITY + 1);

  state_t state, state_next;

  logic [KEY_W-1:0]   in_bc, in_umi;
  logic [CLASS_W-1:0] in_cls, in_merged;
  logic [TOTAL_W-1:0] in_amount;
  logic               in_none, in_range, accept;

  logic [KEY_W-1:0]   cur_bc, cur_umi, pend_bc, pend_umi;
  logic [TOTAL_W-1:0] pend_amount;
  logic               pend_range, key_change, pend_after, ovf;
  logic [FILL_W-1:0]  group_fill;

  logic [MAP_W-1:0]   tbl_rdata;
  cell_cmd_t          cmd;
  logic               do_accum, out_load, last_load, any_hit, store_full;

  entry_t                  cells [GROUP_CAPACITY];
  logic [GROUP_CAPACITY-1:0] hit_vec, valid_vec;

  logic [KEY_W-1:0]   o_bc, o_umi;
  logic [CLASS_W-1:0] o_cls;
  logic [TOTAL_W-1:0] o_total;

  assign in_bc     = s_tdata[KEY_W-1:0];
  assign in_umi    = s_tdata[S_UMI_LO +: KEY_W];
  assign in_cls    = s_tdata[S_CLS_LO +: CLASS_W];
  assign in_amount = s_tdata[S_AMT_LO +: TOTAL_W];
  assign in_merged = s_tdata[S_MRG_LO +: CLASS_W];
  assign in_none   = s_tdata[S_NONE_BIT];
  assign in_range  = 32'(in_cls) < CLASS_TABLE_DEPTH;
  assign accept    = s_tvalid && s_tready;

  rgcm_class_table #(
    .DEPTH  (CLASS_TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (accept && (s_tuser == OP_LOAD) && in_range),
    .waddr (ADDR_W'(in_cls)),
    .wdata ({in_none, in_merged}),
    .re    (accept && (s_tuser == OP_RECORD)),
    .raddr (ADDR_W'(in_cls)),
    .rdata (tbl_rdata)
  );

  // Cell chain: slot zero is the oldest class and feeds the output register.
  for (genvar k = 0; k < GROUP_CAPACITY; k++) begin : g_cell
    logic   prev_valid;
    entry_t nxt;
    if (k == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cells[k-1].valid;
    end
    if (k == GROUP_CAPACITY - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_link
      assign nxt = cells[k+1];
    end
    rgcm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .any_hit    (any_hit),
      .prev_valid (prev_valid),
      .nxt        (nxt),
      .entry      (cells[k]),
      .hit        (hit_vec[k])
    );
    assign valid_vec[k] = cells[k].valid;
  end

  assign any_hit    = |hit_vec;
  assign store_full = group_fill == FILL_W'(GROUP_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (s_tuser == OP_RECORD)) begin
          state_next = ST_LOOKUP;
        end else if (accept && (s_tuser == OP_FLUSH) && (group_fill != '0)) begin
          state_next = ST_EMIT;
        end
      end
      ST_LOOKUP: begin
        if (key_change && (group_fill != '0)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (last_load) begin
          state_next = pend_after ? ST_ACCUM : ST_IDLE;
        end
      end
      ST_ACCUM: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = (state == ST_IDLE);
    out_load   = (state == ST_EMIT) && (!m_tvalid || m_tready);
    last_load  = out_load && (group_fill == FILL_W'(1));
    do_accum   = ((state == ST_LOOKUP) && !(key_change && (group_fill != '0)))
                 || (state == ST_ACCUM);
    cmd.shift  = out_load;
    cmd.accum  = do_accum && pend_range && !tbl_rdata[NONE_IDX];
    cmd.cls    = tbl_rdata[CLASS_W-1:0];
    cmd.amount = pend_amount;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_bc     <= in_bc;
      pend_umi    <= in_umi;
      pend_amount <= in_amount;
      pend_range  <= in_range;
      key_change  <= (in_bc != cur_bc) || (in_umi != cur_umi);
      pend_after  <= (s_tuser == OP_RECORD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bc     <= '0;
      cur_umi    <= '0;
      group_fill <= '0;
      ovf        <= 1'b0;
    end else begin
      if (do_accum) begin
        cur_bc  <= pend_bc;
        cur_umi <= pend_umi;
      end
      if (last_load) begin
        group_fill <= '0;
        ovf        <= 1'b0;
      end else if (out_load) begin
        group_fill <= group_fill - FILL_W'(1);
      end else if (cmd.accum && !any_hit) begin
        if (store_full) begin
          ovf <= 1'b1;
        end else begin
          group_fill <= group_fill + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_bc    <= cur_bc;
      o_umi   <= cur_umi;
      o_cls   <= cells[0].cls;
      o_total <= cells[0].total;
      m_tlast <= (group_fill == FILL_W'(1));
      m_tuser <= ovf;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, o_total, o_cls, o_umi, o_bc};

  `RGCM_ASSERT(a_fill_bound, group_fill <= FILL_W'(GROUP_CAPACITY), "group fill beyond capacity")
  `RGCM_ASSERT(a_fill_matches_cells, $countones(valid_vec) == 32'(group_fill), "fill mismatch")
  `RGCM_ASSERT(a_cells_packed, (valid_vec & (valid_vec + 1'b1)) == '0, "cells not packed")
  `RGCM_ASSERT_NEXT(a_last_empties, last_load, (group_fill == '0) && !ovf, "store not emptied")
  `RGCM_ASSERT(a_emit_nonempty, (state != ST_EMIT) || (group_fill != '0), "empty store emits")

endmodule

@@ hdl/rgcm_class_table.sv @@
// Class map table: one write port, one registered read port.
// Depends on rgcm_pkg for the entry width.
module rgcm_class_table import rgcm_pkg::*; #(
  parameter int DEPTH  = CLASS_TABLE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [MAP_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [MAP_W-1:0]  rdata
);

  logic [MAP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/rgcm_cell.sv @@
// One slot of the group store: holds a merged class and its running total.
// Depends on rgcm_pkg; cells form a chain that shifts toward slot zero.
module rgcm_cell import rgcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      any_hit,
  input  logic      prev_valid,
  input  entry_t    nxt,
  output entry_t    entry,
  output logic      hit
);

  logic capture;

  assign hit = entry.valid && (entry.cls == cmd.cls);
  // The first empty slot takes a class that no slot holds yet.
  assign capture = cmd.accum && !any_hit && !entry.valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (cmd.shift) begin
      entry.valid <= nxt.valid;
    end else if (capture) begin
      entry.valid <= 1'b1;
    end
    if (cmd.shift) begin
      entry.cls   <= nxt.cls;
      entry.total <= nxt.total;
    end else if (cmd.accum && hit) begin
      entry.total <= entry.total + cmd.amount;
    end else if (capture) begin
      entry.cls   <= cmd.cls;
      entry.total <= cmd.amount;
    end
  end

endmodule
